// File: design/fbp_pkg.sv
// ----------------------------------------------------------------------------
// fbp_pkg
// Types, constants and character codes shared by the position parser modules.
// ----------------------------------------------------------------------------
package fbp_pkg;

  localparam int unsigned NUM_PIECES  = 12;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [3:0] IDX_WHITE    = 4'd12;
  localparam logic [3:0] IDX_BLACK    = 4'd13;
  localparam logic [3:0] IDX_ALL      = 4'd14;

  localparam logic [3:0] CURSOR_MAX   = 4'd8;
  localparam logic [3:0] NIBBLE_BAD   = 4'hF;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_ONE       = 8'h31;
  localparam logic [7:0] CH_EIGHT     = 8'h38;
  localparam logic [7:0] CH_LOW_A     = 8'h61;
  localparam logic [7:0] CH_LOW_H     = 8'h68;
  localparam logic [7:0] CH_W         = 8'h77;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_WK        = 8'h4B;
  localparam logic [7:0] CH_WQ        = 8'h51;
  localparam logic [7:0] CH_BK        = 8'h6B;
  localparam logic [7:0] CH_BQ        = 8'h71;

  localparam logic [1:0] CASTLE_WS    = 2'd0;
  localparam logic [1:0] CASTLE_WL    = 2'd1;
  localparam logic [1:0] CASTLE_BS    = 2'd2;
  localparam logic [1:0] CASTLE_BL    = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP        = 3'd0,
    OP_PIECE      = 3'd1,
    OP_SIDE       = 3'd2,
    OP_CASTLE_CLR = 3'd3,
    OP_CASTLE_SET = 3'd4,
    OP_EP_CLEAR   = 3'd5,
    OP_EP_FILE    = 3'd6,
    OP_EP_RANK    = 3'd7
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] slot;
    logic [5:0] arg;
    logic       emit;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
    op_t  head;
  } q_stat_t;

  function automatic logic [4:0] piece_slot(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h4B:   r = {1'b1, 4'd0};
      8'h51:   r = {1'b1, 4'd1};
      8'h52:   r = {1'b1, 4'd2};
      8'h42:   r = {1'b1, 4'd3};
      8'h4E:   r = {1'b1, 4'd4};
      8'h50:   r = {1'b1, 4'd5};
      8'h6B:   r = {1'b1, 4'd6};
      8'h71:   r = {1'b1, 4'd7};
      8'h72:   r = {1'b1, 4'd8};
      8'h62:   r = {1'b1, 4'd9};
      8'h6E:   r = {1'b1, 4'd10};
      8'h70:   r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/fbp_if.sv
// ----------------------------------------------------------------------------
// fbp_if
// Valid/ready channels for the character stream and the board results.
// ----------------------------------------------------------------------------
interface fbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface fbp_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        board_index;
  logic [63:0]       board_bits;
  logic              last_board;
  logic              white_to_move;
  logic              castle_white_short;
  logic              castle_white_long;
  logic              castle_black_short;
  logic              castle_black_long;
  logic              passant_valid;
  logic signed [3:0] passant_file;
  logic signed [3:0] passant_rank;

  modport source (
    output valid, output board_index, output board_bits, output last_board,
    output white_to_move, output castle_white_short, output castle_white_long,
    output castle_black_short, output castle_black_long, output passant_valid,
    output passant_file, output passant_rank, input ready
  );
  modport sink (
    input valid, input board_index, input board_bits, input last_board,
    input white_to_move, input castle_white_short, input castle_white_long,
    input castle_black_short, input castle_black_long, input passant_valid,
    input passant_file, input passant_rank, output ready
  );
endinterface

// File: design/fbp_front.sv
// ----------------------------------------------------------------------------
// fbp_front
// Accepts characters, tracks the field and the cursors, and turns each
// character into at most one board operation for the queue.
// ----------------------------------------------------------------------------
module fbp_front
  import fbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fbp_in_if.sink        in_ch,
  input  logic          q_full,
  output q_wr_t         q_wr
);

  typedef enum logic [6:0] {
    PH_PLACE  = 7'b0000001,
    PH_SIDE   = 7'b0000010,
    PH_SKIP   = 7'b0000100,
    PH_CASTLE = 7'b0001000,
    PH_EPFILE = 7'b0010000,
    PH_EPRANK = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] file_r, file_nxt;
  logic [3:0] rank_r, rank_nxt;
  logic       accept;
  logic [7:0] c;
  logic [4:0] slot;
  op_t        op;

  function automatic logic [3:0] advance(input logic [3:0] f, input logic [3:0] by);
    logic [4:0] s;
    s = {1'b0, f} + {1'b0, by};
    return (s > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : s[3:0];
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign c           = in_ch.symbol;
  assign slot        = piece_slot(c);

  always_comb begin
    phase_nxt = phase_r;
    file_nxt  = file_r;
    rank_nxt  = rank_r;
    op.kind   = OP_NOP;
    op.slot   = 4'd0;
    op.arg    = 6'd0;
    op.emit   = in_ch.end_of_text;
    unique case (phase_r)
      PH_PLACE: begin
        if (c == CH_SPACE) begin
          phase_nxt = PH_SIDE;
        end else if (c == CH_SLASH) begin
          file_nxt = 4'd0;
          if (rank_r < CURSOR_MAX) begin
            rank_nxt = rank_r + 4'd1;
          end
        end else if (slot[4]) begin
          if (file_r < CURSOR_MAX && rank_r < CURSOR_MAX) begin
            op.kind = OP_PIECE;
            op.slot = slot[3:0];
            op.arg  = {~rank_r[2:0], file_r[2:0]};
          end
          file_nxt = advance(file_r, 4'd1);
        end else if (c >= CH_ONE && c <= CH_EIGHT) begin
          file_nxt = advance(file_r, c[3:0]);
        end else begin
          file_nxt = advance(file_r, 4'd1);
        end
      end
      PH_SIDE: begin
        if (c != CH_SPACE) begin
          if (c == CH_W) begin
            op.kind = OP_SIDE;
            op.arg  = 6'd1;
          end else if (c == CH_B) begin
            op.kind = OP_SIDE;
            op.arg  = 6'd0;
          end
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        op.kind   = OP_CASTLE_CLR;
        phase_nxt = PH_CASTLE;
      end
      PH_CASTLE: begin
        if (c == CH_SPACE) begin
          phase_nxt = PH_EPFILE;
        end else if (c == CH_WK) begin
          op.kind = OP_CASTLE_SET;
          op.arg  = {4'd0, CASTLE_WS};
        end else if (c == CH_WQ) begin
          op.kind = OP_CASTLE_SET;
          op.arg  = {4'd0, CASTLE_WL};
        end else if (c == CH_BK) begin
          op.kind = OP_CASTLE_SET;
          op.arg  = {4'd0, CASTLE_BS};
        end else if (c == CH_BQ) begin
          op.kind = OP_CASTLE_SET;
          op.arg  = {4'd0, CASTLE_BL};
        end
      end
      PH_EPFILE: begin
        if (c != CH_SPACE) begin
          if (c == CH_DASH) begin
            op.kind   = OP_EP_CLEAR;
            phase_nxt = PH_DONE;
          end else begin
            op.kind   = OP_EP_FILE;
            op.arg    = {2'd0, (c >= CH_LOW_A && c <= CH_LOW_H) ?
                                 (c[3:0] - 4'd1) : NIBBLE_BAD};
            phase_nxt = PH_EPRANK;
          end
        end
      end
      PH_EPRANK: begin
        op.kind   = OP_EP_RANK;
        op.arg    = {2'd0, (c >= CH_ONE && c <= CH_EIGHT) ?
                             (c[3:0] - 4'd1) : NIBBLE_BAD};
        phase_nxt = PH_DONE;
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_PLACE;
      end
    endcase
    if (in_ch.end_of_text) begin
      phase_nxt = PH_PLACE;
      file_nxt  = 4'd0;
      rank_nxt  = 4'd0;
    end
  end

  assign q_wr.push = accept && (op.kind != OP_NOP || op.emit);
  assign q_wr.op   = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLACE;
      file_r  <= 4'd0;
      rank_r  <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      file_r  <= file_nxt;
      rank_r  <= rank_nxt;
    end
  end

endmodule

// File: design/fbp_queue.sv
// ----------------------------------------------------------------------------
// fbp_queue
// Short FIFO of board operations between the parser front and the board
// back end.
// ----------------------------------------------------------------------------
module fbp_queue
  import fbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_wr_t   q_wr,
  input  logic    pop,
  output q_stat_t q_stat
);

  op_t               ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.head  = ent_r[rd_r];
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= q_wr.op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_stat.full)
    else $error("operation pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// File: design/fbp_back.sv
// ----------------------------------------------------------------------------
// fbp_back
// Holds the piece boards and position flags, applies queued operations, and
// streams the fifteen boards of a finished position through an output
// register.
// ----------------------------------------------------------------------------
module fbp_back
  import fbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  output logic      pop,
  fbp_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t      st_r;
  logic [3:0]  cnt_r;
  logic [63:0] boards_r [NUM_PIECES];
  logic        side_r;
  logic [3:0]  castle_r;
  logic        ep_flag_r;
  logic [3:0]  ep_file_r;
  logic [3:0]  ep_rank_r;
  logic        out_valid_r;
  logic        load;
  logic        finish;
  logic [63:0] white, black, bits_sel;
  op_t         op;

  assign op     = q_stat.head;
  assign pop    = (st_r == ST_RUN) && !q_stat.empty;
  assign load   = (st_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign finish = load && (cnt_r == IDX_ALL);

  always_comb begin
    white = '0;
    black = '0;
    for (int i = 0; i < NUM_PIECES / 2; i++) begin
      white = white | boards_r[i];
      black = black | boards_r[i + NUM_PIECES / 2];
    end
    if (cnt_r == IDX_WHITE) begin
      bits_sel = white;
    end else if (cnt_r == IDX_BLACK) begin
      bits_sel = black;
    end else if (cnt_r == IDX_ALL) begin
      bits_sel = white | black;
    end else if (cnt_r < 4'(NUM_PIECES)) begin
      bits_sel = boards_r[cnt_r];
    end else begin
      bits_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_RUN;
      cnt_r     <= 4'd0;
      side_r    <= 1'b0;
      castle_r  <= 4'd0;
      ep_flag_r <= 1'b0;
      ep_file_r <= 4'd0;
      ep_rank_r <= 4'd0;
      for (int i = 0; i < NUM_PIECES; i++) begin
        boards_r[i] <= '0;
      end
    end else begin
      unique case (st_r)
        ST_RUN: begin
          if (pop) begin
            case (op.kind)
              OP_PIECE:      boards_r[op.slot][op.arg] <= 1'b1;
              OP_SIDE:       side_r <= op.arg[0];
              OP_CASTLE_CLR: castle_r <= 4'd0;
              OP_CASTLE_SET: castle_r[op.arg[1:0]] <= 1'b1;
              OP_EP_CLEAR: begin
                ep_flag_r <= 1'b0;
                ep_file_r <= 4'd0;
                ep_rank_r <= 4'd0;
              end
              OP_EP_FILE: begin
                ep_flag_r <= 1'b1;
                ep_file_r <= op.arg[3:0];
                ep_rank_r <= 4'd0;
              end
              OP_EP_RANK:    ep_rank_r <= op.arg[3:0];
              default: begin
              end
            endcase
            if (op.emit) begin
              st_r  <= ST_EMIT;
              cnt_r <= 4'd0;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            cnt_r <= cnt_r + 4'd1;
          end
          if (finish) begin
            st_r      <= ST_RUN;
            castle_r  <= 4'd0;
            ep_flag_r <= 1'b0;
            ep_file_r <= 4'd0;
            ep_rank_r <= 4'd0;
            for (int i = 0; i < NUM_PIECES; i++) begin
              boards_r[i] <= '0;
            end
          end
        end
        default: begin
          st_r <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.board_index        <= cnt_r;
      out_ch.board_bits         <= bits_sel;
      out_ch.last_board         <= (cnt_r == IDX_ALL);
      out_ch.white_to_move      <= side_r;
      out_ch.castle_white_short <= castle_r[CASTLE_WS];
      out_ch.castle_white_long  <= castle_r[CASTLE_WL];
      out_ch.castle_black_short <= castle_r[CASTLE_BS];
      out_ch.castle_black_long  <= castle_r[CASTLE_BL];
      out_ch.passant_valid      <= ep_flag_r;
      out_ch.passant_file       <= ep_file_r;
      out_ch.passant_rank       <= ep_rank_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_last_is_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.last_board |-> out_ch.board_index == IDX_ALL)
    else $error("last board flag on a board other than the union");

  a_no_pop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EMIT |-> !pop)
    else $error("operation applied while streaming results");

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> boards_r[0] == '0 && castle_r == 4'd0 && !ep_flag_r)
    else $error("position not cleared after the final board");

endmodule

// File: design/fen_board_parser_core.sv
// ----------------------------------------------------------------------------
// fen_board_parser_core
// Parses a FEN body one character per item into twelve piece boards plus
// side, castling and en-passant state, then streams fifteen board results.
// ----------------------------------------------------------------------------
// Throughput: one character item per cycle while the four-entry operation
// queue has room. A final character starts a stream of fifteen board
// results from the board register file; during it the queue takes four
// more operations, characters that make no operation are still taken, and
// the input stalls once the queue is full until the stream ends. The final
// operation passes through the queue and back end to the output register.
// Reset: synchronous, active low; clears all boards, flags and cursors.
// ----------------------------------------------------------------------------
module fen_board_parser_core
  import fbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fbp_in_if.sink    in_ch,
  fbp_out_if.source out_ch
);

  q_wr_t   q_wr;
  q_stat_t q_stat;
  logic    pop;

  fbp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .q_wr   (q_wr)
  );

  fbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_stat (q_stat)
  );

  fbp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: sim/fen_board_parser_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fen_board_parser_core_check
// Watches the character and board channels of the position parser, predicts
// the fifteen board results of every finished string and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module fen_board_parser_core_check
  import fbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fbp_in_if    in_ch,
  fbp_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef enum logic [2:0] {
    FLD_PLACEMENT,
    FLD_SIDE,
    FLD_SIDE_GAP,
    FLD_CASTLING,
    FLD_EP_FILE,
    FLD_EP_RANK,
    FLD_TRAILING
  } fen_field_t;

  typedef struct packed {
    logic [3:0]        index;
    logic [63:0]       bits;
    logic              last;
    logic              white;
    logic [3:0]        rights;
    logic              ep_valid;
    logic signed [3:0] ep_file;
    logic signed [3:0] ep_rank;
  } board_result_t;

  localparam logic [7:0] PIECE_LETTERS [12] = '{
    "K", "Q", "R", "B", "N", "P", "k", "q", "r", "b", "n", "p"
  };

  fen_field_t        field;
  int                file_pos;
  int                row_pos;
  logic [63:0]       boards [12];
  logic              white_side;
  logic [3:0]        rights;
  logic              ep_flag;
  logic signed [3:0] ep_file;
  logic signed [3:0] ep_rank;

  board_result_t     board_queue [$];
  int                errors = 0;

  function automatic int piece_index(input logic [7:0] c);
    for (int i = 0; i < 12; i++) begin
      if (PIECE_LETTERS[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void advance_file(input int by);
    file_pos = (file_pos + by > 8) ? 8 : file_pos + by;
  endfunction

  function automatic void clear_position();
    field    = FLD_PLACEMENT;
    file_pos = 0;
    row_pos  = 0;
    for (int i = 0; i < 12; i++) boards[i] = '0;
    rights   = '0;
    ep_flag  = 1'b0;
    ep_file  = '0;
    ep_rank  = '0;
  endfunction

  function automatic void emit_position();
    logic [63:0]   white_bits;
    logic [63:0]   black_bits;
    board_result_t r;
    white_bits = '0;
    black_bits = '0;
    for (int i = 0; i < 6; i++) begin
      white_bits |= boards[i];
      black_bits |= boards[i + 6];
    end
    for (int k = 0; k < 15; k++) begin
      r.index = 4'(k);
      if (k < 12) r.bits = boards[k];
      else if (4'(k) == IDX_WHITE) r.bits = white_bits;
      else if (4'(k) == IDX_BLACK) r.bits = black_bits;
      else r.bits = white_bits | black_bits;
      r.last     = (4'(k) == IDX_ALL);
      r.white    = white_side;
      r.rights   = rights;
      r.ep_valid = ep_flag;
      r.ep_file  = ep_file;
      r.ep_rank  = ep_rank;
      board_queue.push_back(r);
    end
    clear_position();
  endfunction

  function automatic void take_symbol(input logic [7:0] c, input logic last);
    int slot;
    slot = piece_index(c);
    case (field)
      FLD_PLACEMENT: begin
        if (c == CH_SPACE) begin
          field = FLD_SIDE;
        end else if (c == CH_SLASH) begin
          file_pos = 0;
          if (row_pos < 8) row_pos++;
        end else if (slot >= 0) begin
          if (file_pos < 8 && row_pos < 8) boards[slot][8 * (7 - row_pos) + file_pos] = 1'b1;
          advance_file(1);
        end else if (c >= CH_ONE && c <= CH_EIGHT) begin
          advance_file(int'(c) - int'(CH_ONE) + 1);
        end else begin
          advance_file(1);
        end
      end
      FLD_SIDE: begin
        if (c != CH_SPACE) begin
          if (c == CH_W) white_side = 1'b1;
          if (c == CH_B) white_side = 1'b0;
          field = FLD_SIDE_GAP;
        end
      end
      FLD_SIDE_GAP: begin
        rights = '0;
        field  = FLD_CASTLING;
      end
      FLD_CASTLING: begin
        if (c == CH_SPACE) field = FLD_EP_FILE;
        if (c == CH_WK) rights[CASTLE_WS] = 1'b1;
        if (c == CH_WQ) rights[CASTLE_WL] = 1'b1;
        if (c == CH_BK) rights[CASTLE_BS] = 1'b1;
        if (c == CH_BQ) rights[CASTLE_BL] = 1'b1;
      end
      FLD_EP_FILE: begin
        if (c != CH_SPACE) begin
          ep_flag = 1'b0;
          ep_file = '0;
          ep_rank = '0;
          if (c == CH_DASH) begin
            field = FLD_TRAILING;
          end else begin
            ep_flag = 1'b1;
            ep_file = (c >= CH_LOW_A && c <= CH_LOW_H) ? 4'(c - CH_LOW_A) : NIBBLE_BAD;
            field   = FLD_EP_RANK;
          end
        end
      end
      FLD_EP_RANK: begin
        ep_rank = (c >= CH_ONE && c <= CH_EIGHT) ? 4'(c - CH_ONE) : NIBBLE_BAD;
        field   = FLD_TRAILING;
      end
      default: begin
      end
    endcase
    if (last) emit_position();
  endfunction

  function automatic void check_board();
    board_result_t got;
    board_result_t want;
    got.index    = out_ch.board_index;
    got.bits     = out_ch.board_bits;
    got.last     = out_ch.last_board;
    got.white    = out_ch.white_to_move;
    got.rights   = {out_ch.castle_black_long, out_ch.castle_black_short,
                    out_ch.castle_white_long, out_ch.castle_white_short};
    got.ep_valid = out_ch.passant_valid;
    got.ep_file  = out_ch.passant_file;
    got.ep_rank  = out_ch.passant_rank;
    if (board_queue.size() == 0) begin
      if (errors < 10) begin
        $display("Unexpected board result: index %0d bits %h", got.index, got.bits);
      end
      errors++;
      return;
    end
    want = board_queue.pop_front();
    if (got !== want) begin
      if (errors < 10) begin
        $display({"Board result mismatch: expected index %0d bits %h last %b side %b",
                  " castle %b ep %b %0d %0d"},
                 want.index, want.bits, want.last, want.white, want.rights, want.ep_valid,
                 want.ep_file, want.ep_rank);
        $display({"                       actual   index %0d bits %h last %b side %b",
                  " castle %b ep %b %0d %0d"},
                 got.index, got.bits, got.last, got.white, got.rights, got.ep_valid,
                 got.ep_file, got.ep_rank);
      end
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_position();
      white_side = 1'b0;
      board_queue.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_board();
      if (in_ch.valid && in_ch.ready) take_symbol(in_ch.symbol, in_ch.end_of_text);
    end
    fail_count  <= errors;
    outstanding <= board_queue.size();
  end

endmodule

// File: sim/fen_board_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fen_board_parser_core_tb
// Feeds the position parser short directed strings and then random FEN
// bodies, mostly well formed with random content, some cut short and some
// pure noise, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module fen_board_parser_core_tb;
  import fbp_pkg::*;

  localparam int          SEND_IDLE [3]  = '{37, 68, 0};
  localparam int          RECV_IDLE [3]  = '{68, 37, 0};
  localparam int          PHASE_ITEMS    = 100;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam logic [7:0]  CH_ZERO        = "0";

  localparam logic [7:0] PIECE_LETTERS [12] = '{
    "K", "Q", "R", "B", "N", "P", "k", "q", "r", "b", "n", "p"
  };

  logic        clk = 1'b0;
  logic        rst_n;
  int          send_idle = SEND_IDLE[0];
  int          recv_idle = RECV_IDLE[0];
  int unsigned cycles = 0;
  int          fail_count;
  int          outstanding;
  logic [7:0]  fen_text [$];

  fbp_in_if  in_ch ();
  fbp_out_if out_ch ();

  fen_board_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fen_board_parser_core_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("fen_board_parser_core_tb NOT OK");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= c;
    in_ch.end_of_text <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < fen_text.size(); i++) send_char(fen_text[i], i == fen_text.size() - 1);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] placement_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return PIECE_LETTERS[$urandom_range(0, 11)];
    if (pick < 9) return CH_ONE + 8'($urandom_range(0, 7));
    return any_byte();
  endfunction

  function automatic void compose_fen();
    int rows;
    int pick;
    int keep;
    fen_text.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) fen_text.push_back(any_byte());
      return;
    end
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : 8;
    for (int r = 0; r < rows; r++) begin
      if (r > 0) fen_text.push_back(CH_SLASH);
      repeat ($urandom_range(1, 3)) fen_text.push_back(placement_char());
    end
    fen_text.push_back(CH_SPACE);
    if ($urandom_range(0, 3) == 0) fen_text.push_back(CH_SPACE);
    pick = $urandom_range(0, 9);
    fen_text.push_back(pick < 5 ? CH_W : (pick < 9 ? CH_B : any_byte()));
    fen_text.push_back($urandom_range(0, 7) == 0 ? any_byte() : CH_SPACE);
    if ($urandom_range(0, 3) == 0) begin
      fen_text.push_back(CH_DASH);
    end else begin
      if ($urandom_range(0, 1)) fen_text.push_back(CH_WK);
      if ($urandom_range(0, 1)) fen_text.push_back(CH_WQ);
      if ($urandom_range(0, 1)) fen_text.push_back(CH_BK);
      if ($urandom_range(0, 1)) fen_text.push_back(CH_BQ);
      if ($urandom_range(0, 5) == 0) fen_text.push_back(any_byte());
      if (fen_text[$] == CH_SPACE) fen_text.push_back(CH_DASH);
    end
    fen_text.push_back(CH_SPACE);
    if ($urandom_range(0, 3) == 0) fen_text.push_back(CH_SPACE);
    if ($urandom_range(0, 1)) begin
      fen_text.push_back(CH_DASH);
    end else begin
      fen_text.push_back($urandom_range(0, 6) == 0 ? any_byte()
                                                  : CH_LOW_A + 8'($urandom_range(0, 7)));
      fen_text.push_back($urandom_range(0, 6) == 0 ? any_byte()
                                                  : CH_ONE + 8'($urandom_range(0, 7)));
    end
    if ($urandom_range(0, 1)) begin
      fen_text.push_back(CH_SPACE);
      fen_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      fen_text.push_back(CH_SPACE);
      fen_text.push_back(CH_ONE + 8'($urandom_range(0, 8)));
    end
    if ($urandom_range(0, 6) == 0) begin
      keep = $urandom_range(1, fen_text.size());
      while (fen_text.size() > keep) void'(fen_text.pop_back());
    end
  endfunction

  initial begin
    int sent;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.end_of_text <= 1'b0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Off-board placements, a piece on the next row, then a short string.
    send_string("7NNk/p");
    // Every castling letter and an en-passant square with bad file and rank.
    send_string("K w KQkq i0");
    // Unknown side letter keeps white from the string before.
    send_string("q x - h8");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    wait_for_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = SEND_IDLE[ph];
      recv_idle = RECV_IDLE[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        compose_fen();
        send_text();
        sent += fen_text.size();
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("fen_board_parser_core_tb OK");
    end else begin
      $display("fen_board_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fbp_pkg.sv
design/fbp_if.sv
design/fbp_front.sv
design/fbp_queue.sv
design/fbp_back.sv
design/fen_board_parser_core.sv
sim/fen_board_parser_core_check.sv
sim/fen_board_parser_core_tb.sv
